[rtl/pat_pkg.sv]
// Shared types and constants of the 3D affine point transform.
// No dependencies; imported by the transform modules.
package pat_pkg;

    typedef enum logic [2:0] {
        ACT_TRANSLATE = 3'd0,
        ACT_SCALE     = 3'd1,
        ACT_ROT_X     = 3'd2,
        ACT_ROT_Y     = 3'd3,
        ACT_ROT_Z     = 3'd4
    } t_action;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_CENTER_Z = 2'd2;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_ZERO_SCALE = 1'b1;

    // inverse of the zero-scale threshold (1e-7)
    localparam int ZERO_EPS_INV = 10000000;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

[rtl/pat_in_if.sv]
// Input channel of the point transform: one point with action and arguments per beat.
// No dependencies.
interface pat_in_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic [2:0]                    action;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] arg_a;
    logic signed [COORD_WIDTH-1:0] arg_b;
    logic signed [COORD_WIDTH-1:0] arg_c;
    logic                          last_point;

    modport source (output valid, action, point_x, point_y, point_z,
                    arg_a, arg_b, arg_c, last_point, input ready);
    modport sink   (input valid, action, point_x, point_y, point_z,
                    arg_a, arg_b, arg_c, last_point, output ready);
endinterface

[rtl/pat_out_if.sv]
// Output channel of the point transform: one transformed point per beat.
// No dependencies.
interface pat_out_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          status;
    logic                          last_out;

    modport source (output valid, out_x, out_y, out_z, status, last_out, input ready);
    modport sink   (input valid, out_x, out_y, out_z, status, last_out, output ready);
endinterface

[rtl/pat_operand.sv]
// Stage 1: decodes the action into two multiplier operand pairs and an addend per axis.
// Depends on pat_pkg.
module pat_operand #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [2:0]                    i_action,
    input  logic signed [COORD_WIDTH-1:0] i_pt     [3],
    input  logic signed [COORD_WIDTH-1:0] i_arg    [3],
    input  logic signed [COORD_WIDTH-1:0] i_center [3],
    input  logic                          i_last,
    output logic signed [COORD_WIDTH:0]   o_m1     [3],
    output logic signed [COORD_WIDTH:0]   o_n1     [3],
    output logic signed [COORD_WIDTH:0]   o_m2     [3],
    output logic signed [COORD_WIDTH:0]   o_n2     [3],
    output logic [2:0]                    o_neg,
    output logic signed [COORD_WIDTH:0]   o_add    [3],
    output logic                          o_status,
    output logic                          o_last
);
    import pat_pkg::*;

    localparam int XW = COORD_WIDTH + 1;
    localparam int ZERO_LIM = ((1 << FRACTION_BITS) + ZERO_EPS_INV - 1) / ZERO_EPS_INV;
    localparam logic signed [XW-1:0] ONE   = {{(XW-1){1'b0}}, 1'b1} << FRACTION_BITS;
    localparam logic signed [XW-1:0] LIM_P = XW'(ZERO_LIM);
    localparam logic signed [XW-1:0] LIM_N = -LIM_P;

    logic signed [XW-1:0] px [3];
    logic signed [XW-1:0] ax [3];
    logic signed [XW-1:0] cx [3];
    logic [2:0]           zero_k;

    logic signed [XW-1:0] n_m1  [3];
    logic signed [XW-1:0] n_n1  [3];
    logic signed [XW-1:0] n_m2  [3];
    logic signed [XW-1:0] n_n2  [3];
    logic signed [XW-1:0] n_add [3];
    logic [2:0]           n_neg;
    logic                 n_status;

    logic signed [XW-1:0] r_m1  [3];
    logic signed [XW-1:0] r_n1  [3];
    logic signed [XW-1:0] r_m2  [3];
    logic signed [XW-1:0] r_n2  [3];
    logic signed [XW-1:0] r_add [3];
    logic [2:0]           r_neg;
    logic                 r_status;
    logic                 r_last;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            px[j]     = {i_pt[j][COORD_WIDTH-1], i_pt[j]};
            ax[j]     = {i_arg[j][COORD_WIDTH-1], i_arg[j]};
            cx[j]     = {i_center[j][COORD_WIDTH-1], i_center[j]};
            zero_k[j] = (ax[j] < LIM_P) && (ax[j] > LIM_N);
        end
    end

    always_comb begin
        logic [1:0]           iu;
        logic [1:0]           iv;
        logic                 rot;
        logic signed [XW-1:0] du;
        logic signed [XW-1:0] dv;
        for (int j = 0; j < 3; j++) begin
            n_m1[j]  = '0;
            n_n1[j]  = '0;
            n_m2[j]  = '0;
            n_n2[j]  = '0;
            n_add[j] = px[j];
        end
        n_neg    = '0;
        n_status = STATUS_OK;
        rot      = 1'b0;
        iu       = AX_X;
        iv       = AX_Y;
        unique case (t_action'(i_action))
            ACT_TRANSLATE: begin
                for (int j = 0; j < 3; j++) n_add[j] = px[j] + ax[j];
            end
            ACT_SCALE: begin
                if (|zero_k) begin
                    n_status = STATUS_ZERO_SCALE;
                end else begin
                    for (int j = 0; j < 3; j++) begin
                        n_m1[j]  = ax[j];
                        n_n1[j]  = px[j];
                        n_m2[j]  = cx[j];
                        n_n2[j]  = ONE - ax[j];
                        n_add[j] = '0;
                    end
                end
            end
            ACT_ROT_X: begin
                rot = 1'b1;
                iu  = AX_Y;
                iv  = AX_Z;
            end
            ACT_ROT_Y: begin
                rot = 1'b1;
                iu  = AX_Z;
                iv  = AX_X;
            end
            ACT_ROT_Z: begin
                rot = 1'b1;
                iu  = AX_X;
                iv  = AX_Y;
            end
            default: ;
        endcase
        du = px[iu] - cx[iu];
        dv = px[iv] - cx[iv];
        if (rot) begin
            n_m1[iu]  = du;
            n_n1[iu]  = ax[0];
            n_m2[iu]  = dv;
            n_n2[iu]  = ax[1];
            n_add[iu] = cx[iu];
            n_m1[iv]  = dv;
            n_n1[iv]  = ax[0];
            n_m2[iv]  = du;
            n_n2[iv]  = ax[1];
            n_add[iv] = cx[iv];
            n_neg[iv] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1     <= n_m1;
            r_n1     <= n_n1;
            r_m2     <= n_m2;
            r_n2     <= n_n2;
            r_add    <= n_add;
            r_neg    <= n_neg;
            r_status <= n_status;
            r_last   <= i_last;
        end
    end

    assign o_m1     = r_m1;
    assign o_n1     = r_n1;
    assign o_m2     = r_m2;
    assign o_n2     = r_n2;
    assign o_add    = r_add;
    assign o_neg    = r_neg;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

[rtl/pat_mul.sv]
// Two-stage signed multiplier: split partial products, then sum and truncate toward zero.
// Depends on pat_pkg.
module pat_mul #(
    parameter int OW = 33,
    parameter int F  = 16
) (
    input  logic                   i_clk,
    input  pat_pkg::t_stage_en     i_en,
    input  logic signed [OW-1:0]   i_a,
    input  logic signed [OW-1:0]   i_b,
    output logic signed [2*OW-F-1:0] o_t
);
    import pat_pkg::*;

    localparam int L   = OW / 2;
    localparam int HW  = OW - L;
    localparam int PW2 = 2 * OW;
    localparam logic signed [PW2-1:0] RND = ({{(PW2-1){1'b0}}, 1'b1} << F) - 1'b1;

    logic signed [OW+L:0]      r_pp_lo;
    logic signed [OW+HW-1:0]   r_pp_hi;
    logic signed [PW2-1:0]     full;
    logic signed [PW2-1:0]     adj;
    logic signed [2*OW-F-1:0]  r_t;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_pp_lo <= i_a * $signed({1'b0, i_b[L-1:0]});
            r_pp_hi <= i_a * $signed(i_b[OW-1:L]);
        end
    end

    always_comb begin
        full = (PW2'(r_pp_hi) <<< L) + PW2'(r_pp_lo);
        adj  = full + (full[PW2-1] ? RND : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) r_t <= adj[PW2-1:F];
    end

    assign o_t = r_t;

endmodule

[rtl/pat_combine.sv]
// Final stage: truncated products t1 +/- t2 plus the addend, saturated per axis.
// Depends on pat_pkg.
module pat_combine #(
    parameter int COORD_WIDTH = 32,
    parameter int PW          = 50
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [PW-1:0]          i_t1  [3],
    input  logic signed [PW-1:0]          i_t2  [3],
    input  logic [2:0]                    i_neg,
    input  logic signed [COORD_WIDTH:0]   i_add [3],
    input  logic                          i_status,
    input  logic                          i_last,
    output logic signed [COORD_WIDTH-1:0] o_p   [3],
    output logic                          o_status,
    output logic                          o_last
);
    import pat_pkg::*;

    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] SAT_HI =
        {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO =
        {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    logic signed [SW-1:0]          sum [3];
    logic signed [COORD_WIDTH-1:0] n_p [3];
    logic signed [COORD_WIDTH-1:0] r_p [3];
    logic                          r_status;
    logic                          r_last;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sum[j] = SW'(i_t1[j]) + (i_neg[j] ? -SW'(i_t2[j]) : SW'(i_t2[j]))
                     + SW'(i_add[j]);
            if (sum[j] > SAT_HI) begin
                n_p[j] = SAT_HI[COORD_WIDTH-1:0];
            end else if (sum[j] < SAT_LO) begin
                n_p[j] = SAT_LO[COORD_WIDTH-1:0];
            end else begin
                n_p[j] = sum[j][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p      <= n_p;
            r_status <= i_status;
            r_last   <= i_last;
        end
    end

    assign o_p      = r_p;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

[rtl/point_affine_transform_3d_unit.sv]
// Top level of the 3D affine point transform: center registers, stage valids, datapath.
// Depends on pat_pkg, pat_in_if, pat_out_if, pat_operand, pat_mul, pat_combine.
//
// Usage:
//   i_pt carries one point per beat with its action (translate, scale about the
//   center, rotate about the center around x, y or z) and three arguments; o_res
//   returns one transformed, saturated point per beat with status and last flag.
//   The center is set through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it
//   only while idle, which the block itself does not enforce. Stages to o_res.valid:
//     stage 1 operand decode, stage 2 partial products, stage 3 product sum and
//     truncation, stage 4 final add and saturation (output register).
//   Throughput: one point per cycle while o_res.ready is high; all four stages are fully pipelined.
//   Stall: each stage holds while the one after it is full and stalled; empty
//   stages still take data, so up to four beats are buffered and none are lost.
//   Reset: synchronous active-low i_rst_n clears all stage valids and the centers;
//   i_pt.ready is low while reset is held.
module point_affine_transform_3d_unit #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    pat_in_if.sink                 i_pt,
    pat_out_if.source              o_res
);
    import pat_pkg::*;

    localparam int XW = COORD_WIDTH + 1;
    localparam int PW = 2 * XW - FRACTION_BITS;

    logic signed [COORD_WIDTH-1:0] r_center [3];
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    t_stage_en en;

    logic signed [COORD_WIDTH-1:0] pt  [3];
    logic signed [COORD_WIDTH-1:0] arg [3];

    logic signed [XW-1:0] m1 [3];
    logic signed [XW-1:0] n1 [3];
    logic signed [XW-1:0] m2 [3];
    logic signed [XW-1:0] n2 [3];
    logic signed [XW-1:0] add1 [3];
    logic [2:0]           neg1;
    logic                 status1;
    logic                 last1;

    logic signed [XW-1:0] r_add2 [3];
    logic signed [XW-1:0] r_add3 [3];
    logic [2:0]           r_neg2, r_neg3;
    logic                 r_status2, r_status3;
    logic                 r_last2, r_last3;

    logic signed [PW-1:0] t1 [3];
    logic signed [PW-1:0] t2 [3];

    logic signed [COORD_WIDTH-1:0] res [3];
    logic                          res_status;
    logic                          res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X: r_center[0] <= i_cfg_data;
                CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign rdy4 = !r_v4 || o_res.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign i_pt.ready = rdy1 && i_rst_n;

    always_comb begin
        en.s1 = rdy1 && i_pt.valid;
        en.s2 = rdy2 && r_v1;
        en.s3 = rdy3 && r_v2;
        en.s4 = rdy4 && r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_pt.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    assign pt[0]  = i_pt.point_x;
    assign pt[1]  = i_pt.point_y;
    assign pt[2]  = i_pt.point_z;
    assign arg[0] = i_pt.arg_a;
    assign arg[1] = i_pt.arg_b;
    assign arg[2] = i_pt.arg_c;

    pat_operand #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_operand (
        .i_clk    (i_clk),
        .i_en     (en.s1),
        .i_action (i_pt.action),
        .i_pt     (pt),
        .i_arg    (arg),
        .i_center (r_center),
        .i_last   (i_pt.last_point),
        .o_m1     (m1),
        .o_n1     (n1),
        .o_m2     (m2),
        .o_n2     (n2),
        .o_neg    (neg1),
        .o_add    (add1),
        .o_status (status1),
        .o_last   (last1)
    );

    for (genvar j = 0; j < 3; j++) begin : g_axis
        pat_mul #(.OW(XW), .F(FRACTION_BITS)) u_mul1 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (m1[j]),
            .i_b   (n1[j]),
            .o_t   (t1[j])
        );
        pat_mul #(.OW(XW), .F(FRACTION_BITS)) u_mul2 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (m2[j]),
            .i_b   (n2[j]),
            .o_t   (t2[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en.s2) begin
            r_add2    <= add1;
            r_neg2    <= neg1;
            r_status2 <= status1;
            r_last2   <= last1;
        end
        if (en.s3) begin
            r_add3    <= r_add2;
            r_neg3    <= r_neg2;
            r_status3 <= r_status2;
            r_last3   <= r_last2;
        end
    end

    pat_combine #(
        .COORD_WIDTH (COORD_WIDTH),
        .PW          (PW)
    ) u_combine (
        .i_clk    (i_clk),
        .i_en     (en.s4),
        .i_t1     (t1),
        .i_t2     (t2),
        .i_neg    (r_neg3),
        .i_add    (r_add3),
        .i_status (r_status3),
        .i_last   (r_last3),
        .o_p      (res),
        .o_status (res_status),
        .o_last   (res_last)
    );

    assign o_res.valid    = r_v4;
    assign o_res.out_x    = res[0];
    assign o_res.out_y    = res[1];
    assign o_res.out_z    = res[2];
    assign o_res.status   = res_status;
    assign o_res.last_out = res_last;

endmodule

[rtl/pat_checker.sv]
// Port-level assertions for the point transform top level, with its bind statement.
// Depends on point_affine_transform_3d_unit and its channel interfaces.
module pat_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [3*COORD_WIDTH+1:0]   i_out_data
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input not ready while output side can move");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 4))
        else $error("output beat without input beat four cycles earlier");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled output beat changed");

endmodule

bind point_affine_transform_3d_unit pat_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  ({o_res.out_x, o_res.out_y, o_res.out_z, o_res.status, o_res.last_out})
);

[bench/point_transform_scoreboard.sv]
`timescale 1ns / 1ps
// Scoreboard for the 3D affine point transform: keeps its own copy of the center registers
// and predicts every output beat from the input beats, then compares field by field.
// Depends on pat_pkg, pat_in_if and pat_out_if.
module point_transform_scoreboard #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    pat_in_if                      i_pt,
    pat_out_if                     i_res,
    output int                     o_errors,
    output int                     o_pending
);
    import pat_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [127:0]           wide_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
        logic                   status;
        logic                   last;
    } point_result_t;

    coord_t        center_x = '0;
    coord_t        center_y = '0;
    coord_t        center_z = '0;
    point_result_t expected_points[$];
    int            mismatches = 0;
    int            pending = 0;
    int            beats_out = 0;

    assign o_errors  = mismatches;
    assign o_pending = pending;

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch at output beat %0d: %s", $time, beats_out, what);
        mismatches++;
    endtask

    // exact product, shifted down toward zero
    function automatic wide_t fx_mul(input wide_t a, input wide_t b);
        wide_t p;
        p = a * b;
        return (p < 0) ? -((-p) >>> FRACTION_BITS) : (p >>> FRACTION_BITS);
    endfunction

    function automatic coord_t saturate(input wide_t v);
        wide_t top_lim, bot_lim;
        top_lim = (wide_t'(1) <<< (COORD_WIDTH - 1)) - 1;
        bot_lim = -top_lim - 1;
        if (v > top_lim)
            return coord_t'(top_lim);
        if (v < bot_lim)
            return coord_t'(bot_lim);
        return coord_t'(v);
    endfunction

    function automatic logic zero_factor(input coord_t k);
        wide_t m, one;
        m   = (k < 0) ? -wide_t'(k) : wide_t'(k);
        one = wide_t'(1) <<< FRACTION_BITS;
        return (m < one) && (m * ZERO_EPS_INV < one);
    endfunction

    function automatic coord_t scale_axis(input coord_t p, input coord_t k, input coord_t c);
        wide_t one;
        one = wide_t'(1) <<< FRACTION_BITS;
        return saturate(fx_mul(k, p) + fx_mul(c, one - wide_t'(k)));
    endfunction

    // first' = du*cos + dv*sin + cu, second' = dv*cos - du*sin + cv
    function automatic void rotate_pair(input coord_t u, v, cu, cv, cs, sn,
                                        output coord_t ou, ov);
        wide_t du, dv;
        du = wide_t'(u) - wide_t'(cu);
        dv = wide_t'(v) - wide_t'(cv);
        ou = saturate(fx_mul(du, cs) + fx_mul(dv, sn) + wide_t'(cu));
        ov = saturate(fx_mul(dv, cs) - fx_mul(du, sn) + wide_t'(cv));
    endfunction

    function automatic point_result_t transform_point(input logic [2:0] act,
                                                      input coord_t x, y, z, a, b, c,
                                                      input logic last);
        point_result_t r;
        coord_t        nx, ny, nz;
        nx = x;
        ny = y;
        nz = z;
        r.status = STATUS_OK;
        r.last   = last;
        case (act)
            ACT_TRANSLATE: begin
                nx = saturate(wide_t'(x) + wide_t'(a));
                ny = saturate(wide_t'(y) + wide_t'(b));
                nz = saturate(wide_t'(z) + wide_t'(c));
            end
            ACT_SCALE: begin
                if (zero_factor(a) || zero_factor(b) || zero_factor(c)) begin
                    r.status = STATUS_ZERO_SCALE;
                end else begin
                    nx = scale_axis(x, a, center_x);
                    ny = scale_axis(y, b, center_y);
                    nz = scale_axis(z, c, center_z);
                end
            end
            ACT_ROT_X: rotate_pair(y, z, center_y, center_z, a, b, ny, nz);
            ACT_ROT_Y: rotate_pair(z, x, center_z, center_x, a, b, nz, nx);
            ACT_ROT_Z: rotate_pair(x, y, center_x, center_y, a, b, nx, ny);
            default: ;
        endcase
        r.x = nx;
        r.y = ny;
        r.z = nz;
        return r;
    endfunction

    always @(posedge i_clk) begin
        point_result_t want;
        if (!i_rst_n) begin
            center_x = '0;
            center_y = '0;
            center_z = '0;
            expected_points.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_points.size() == 0) begin
                    flag_mismatch("beat with no point outstanding");
                end else begin
                    want = expected_points.pop_front();
                    if (i_res.out_x !== want.x)
                        flag_mismatch($sformatf("out_x got %0d want %0d",
                                                $signed(i_res.out_x), $signed(want.x)));
                    if (i_res.out_y !== want.y)
                        flag_mismatch($sformatf("out_y got %0d want %0d",
                                                $signed(i_res.out_y), $signed(want.y)));
                    if (i_res.out_z !== want.z)
                        flag_mismatch($sformatf("out_z got %0d want %0d",
                                                $signed(i_res.out_z), $signed(want.z)));
                    if (i_res.status !== want.status)
                        flag_mismatch($sformatf("status got %b want %b",
                                                i_res.status, want.status));
                    if (i_res.last_out !== want.last)
                        flag_mismatch($sformatf("last_out got %b want %b",
                                                i_res.last_out, want.last));
                end
                beats_out++;
            end
            if (i_pt.valid && i_pt.ready)
                expected_points.push_back(transform_point(i_pt.action, i_pt.point_x,
                    i_pt.point_y, i_pt.point_z, i_pt.arg_a, i_pt.arg_b, i_pt.arg_c,
                    i_pt.last_point));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CENTER_X: center_x = i_cfg_data;
                    CFG_CENTER_Y: center_y = i_cfg_data;
                    CFG_CENTER_Z: center_z = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending = expected_points.size();
    end

endmodule

[bench/point_affine_transform_3d_unit_test.sv]
`timescale 1ns / 1ps
// Top of the point transform bench: clock, reset, center writes, point stimulus with
// random gaps and output stalls, watchdog and verdict. Checking is in the scoreboard.
// Depends on pat_pkg, pat_in_if, pat_out_if, point_transform_scoreboard and the unit.
module point_affine_transform_3d_unit_test;
    import pat_pkg::*;

    localparam int COORD_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASES        = 8;
    localparam int PHASE_POINTS  = 175;

    localparam int         ACT_SPARE_FIRST = 5;
    localparam int         ACT_SPARE_LAST  = 7;
    localparam logic [1:0] CFG_UNUSED      = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t C_MAX  = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam coord_t C_MIN  = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
    localparam coord_t ONE_FX = coord_t'(1) <<< FRACTION_BITS;
    localparam coord_t HALF   = coord_t'(1) <<< (FRACTION_BITS - 1);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [1:0]             cfg_idx;
    logic [COORD_WIDTH-1:0] cfg_data;

    int mismatch_count;
    int points_pending;
    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int src_burst = 0;
    int sink_burst = 0;
    int idle_cycles = 0;

    pat_in_if  #(.COORD_WIDTH(COORD_WIDTH)) pt_if ();
    pat_out_if #(.COORD_WIDTH(COORD_WIDTH)) res_if ();

    point_affine_transform_3d_unit #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_if),
        .o_res      (res_if)
    );

    point_transform_scoreboard #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) scoreboard (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_if),
        .i_res      (res_if),
        .o_errors   (mismatch_count),
        .o_pending  (points_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (sink_burst > 0) begin
            sink_burst <= sink_burst - 1;
            res_if.ready <= 1'b1;
        end else begin
            if ($urandom_range(0, 99) < 2)
                sink_burst <= $urandom_range(10, 40);
            res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic coord_t rand_coord();
        coord_t v;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? C_MAX : C_MIN;
            1, 2, 3, 4: begin
                v = coord_t'($urandom_range(0, 24'hff_ffff));
                return $urandom_range(0, 1) ? -v : v;
            end
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic coord_t rand_factor();
        coord_t v;
        case ($urandom_range(0, 19))
            0: return '0;
            1: return $urandom_range(0, 1) ? coord_t'(1) : -coord_t'(1);
            2, 3, 4, 5, 6, 7: return rand_coord();
            default: begin
                v = coord_t'($urandom_range(0, 4 * ONE_FX));
                return $urandom_range(0, 1) ? -v : v;
            end
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_point(input logic [2:0] act, input coord_t x, y, z, a, b, c,
                              input logic last);
        if (src_burst > 0)
            src_burst--;
        else if ($urandom_range(0, 99) < 4)
            src_burst = $urandom_range(10, 40);
        while (src_burst == 0 && $urandom_range(0, 99) < src_gap_pct) begin
            pt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_if.valid      <= 1'b1;
        pt_if.action     <= act;
        pt_if.point_x    <= x;
        pt_if.point_y    <= y;
        pt_if.point_z    <= z;
        pt_if.arg_a      <= a;
        pt_if.arg_b      <= b;
        pt_if.arg_c      <= c;
        pt_if.last_point <= last;
        @(posedge i_clk);
        while (!pt_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        pt_if.valid <= 1'b0;
        while (points_pending != 0)
            @(negedge i_clk);
    endtask

    task automatic load_centers(input coord_t cx, cy, cz);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_UNUSED;
        cfg_data <= $urandom;
        @(negedge i_clk);
        cfg_idx  <= CFG_CENTER_X;
        cfg_data <= cx;
        @(negedge i_clk);
        cfg_idx  <= CFG_CENTER_Y;
        cfg_data <= cy;
        @(negedge i_clk);
        cfg_idx  <= CFG_CENTER_Z;
        cfg_data <= cz;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int         sel;
        logic [2:0] act;
        coord_t     a, b, c;
        real        ang;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_CENTER_X;
        cfg_data         = '0;
        pt_if.valid      = 1'b0;
        pt_if.action     = ACT_TRANSLATE;
        pt_if.point_x    = '0;
        pt_if.point_y    = '0;
        pt_if.point_z    = '0;
        pt_if.arg_a      = '0;
        pt_if.arg_b      = '0;
        pt_if.arg_c      = '0;
        pt_if.last_point = 1'b0;
        res_if.ready     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: saturation both ways, zero factor per axis, smallest factors,
        // truncation toward zero, unit rotations, extremes, unused action codes
        send_point(ACT_TRANSLATE, C_MAX, C_MIN, ONE_FX, C_MAX, C_MIN, -ONE_FX, 1'b0);
        send_point(ACT_TRANSLATE, C_MIN, C_MAX, '0, -coord_t'(1), coord_t'(1), '0, 1'b1);
        send_point(ACT_SCALE, ONE_FX, C_MAX, C_MIN, '0, ONE_FX, ONE_FX, 1'b0);
        send_point(ACT_SCALE, ONE_FX, C_MAX, C_MIN, ONE_FX, '0, ONE_FX, 1'b0);
        send_point(ACT_SCALE, ONE_FX, C_MAX, C_MIN, ONE_FX, ONE_FX, '0, 1'b1);
        send_point(ACT_SCALE, C_MAX, C_MIN, ONE_FX, coord_t'(1), -coord_t'(1), coord_t'(1),
                   1'b0);
        send_point(ACT_SCALE, -coord_t'(3), coord_t'(3), C_MIN, HALF, -HALF, C_MIN, 1'b0);
        send_point(ACT_SCALE, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, 1'b1);
        for (int axis = ACT_ROT_X; axis <= ACT_ROT_Z; axis++) begin
            send_point(3'(axis), ONE_FX, -ONE_FX, HALF, ONE_FX, '0, '0, 1'b0);
            send_point(3'(axis), ONE_FX, -ONE_FX, HALF, '0, ONE_FX, C_MAX, 1'b0);
            send_point(3'(axis), C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, 1'b1);
        end
        for (int code = ACT_SPARE_FIRST; code <= ACT_SPARE_LAST; code++)
            send_point(3'(code), rand_coord(), rand_coord(), rand_coord(), '0, '0, '0,
                       1'(code));
        send_point(ACT_ROT_Z, '1, '1, '1, '1, '1, '1, 1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: load_centers(coord_t'($urandom_range(0, 255)) <<< FRACTION_BITS,
                                -ONE_FX, HALF);
                1: load_centers(C_MAX, C_MAX, C_MAX);
                2: load_centers(C_MIN, C_MIN, C_MIN);
                3: load_centers(C_MAX, '0, C_MIN);
                default: load_centers(rand_coord(), rand_coord(), rand_coord());
            endcase
            case (phase % 4)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 66; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 66; end
                default: begin src_gap_pct = 38; sink_stall_pct = 38; end
            endcase
            for (int n = 0; n < PHASE_POINTS; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 18)
                    act = ACT_TRANSLATE;
                else if (sel < 42)
                    act = ACT_SCALE;
                else if (sel < 92)
                    act = 3'(ACT_ROT_X + $urandom_range(0, 2));
                else
                    act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
                case (act)
                    ACT_SCALE: begin
                        a = rand_factor();
                        b = rand_factor();
                        c = rand_factor();
                    end
                    ACT_ROT_X, ACT_ROT_Y, ACT_ROT_Z: begin
                        if ($urandom_range(0, 4) == 0) begin
                            a = rand_coord();
                            b = rand_coord();
                        end else begin
                            ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
                            a = coord_t'($rtoi($cos(ang) * real'(ONE_FX)));
                            b = coord_t'($rtoi($sin(ang) * real'(ONE_FX)));
                        end
                        c = coord_t'($urandom);
                    end
                    default: begin
                        a = rand_coord();
                        b = rand_coord();
                        c = rand_coord();
                    end
                endcase
                send_point(act, rand_coord(), rand_coord(), rand_coord(), a, b, c,
                           1'($urandom_range(0, 1)));
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
